// ===== rtl/core/aslhvt_pkg.sv =====
package aslhvt_pkg;

  localparam int TableDepth = 256;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);

  localparam logic [63:0] FnvBasis = 64'hcbf29ce484222325;
  localparam logic [63:0] FnvPrime = 64'h00000100000001b3;
  localparam logic [15:0] ChEsc = 16'h001b;
  localparam logic [15:0] ChLbracket = 16'h005b;
  localparam logic [15:0] ChSemi = 16'h003b;
  localparam logic [15:0] ChQuest = 16'h003f;

  localparam logic [1:0] CmdChar = 2'd0;
  localparam logic [1:0] CmdRecord = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  localparam logic [1:0] VerdNone = 2'd0;
  localparam logic [1:0] VerdDanger = 2'd1;
  localparam logic [1:0] VerdTrust = 2'd2;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StBadVerdict = 2'd2;
  localparam logic [1:0] StNoKey = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] ch;
    logic        end_of_line;
    logic [1:0]  verdict_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0] line_key;
    logic        found;
    logic [1:0]  verdict_out;
    logic [8:0]  dangerous_total;
    logic [8:0]  trusted_total;
    logic [1:0]  status;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;      // capture the input item
    logic fold;       // one byte fold step (xor + multiply)
    logic fold_done;  // close the character: mode update, maybe end line
    logic scan_init;  // start a table scan for the chosen key
    logic scan_step;  // compare one entry
    logic commit;     // apply the command and emit the result
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       fold_ch;     // the latched character itself is hashed
    logic       esc_first;   // a pending ESC is hashed before the character
    logic       line_end;    // this character closes the line
    logic       scan_done;   // scan reached the end of the valid entries
    logic [1:0] cmd;
  } dp_stat_t;

endpackage

// ===== rtl/core/aslhvt_datapath.sv =====
module aslhvt_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  aslhvt_pkg::in_item_t  in_item,
  input  aslhvt_pkg::dp_cmd_t   cmd_i,
  output aslhvt_pkg::dp_stat_t  stat_o,
  output aslhvt_pkg::out_item_t out_item,
  output logic                  out_strobe
);
  import aslhvt_pkg::*;

  typedef enum logic [1:0] {ModeNormal = 2'd0, ModeEsc = 2'd1, ModeCsi = 2'd2} mode_t;

  in_item_t    item_r;
  mode_t       mode_r, mode_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [63:0] prev_key_r, prev_key_nxt;
  logic        key_ready_r, key_ready_nxt;
  logic [CntW-1:0] entry_count_r, entry_count_nxt;
  logic [CntW-1:0] dang_r, dang_nxt, trust_r, trust_nxt;
  logic [1:0]  byte_sel_r, byte_sel_nxt;   // bytes folded so far for this character
  logic [CntW-1:0] scan_idx_r;
  logic        hit_r;
  logic [IdxW-1:0] hit_idx_r;
  logic [1:0]  hit_verd_r;
  logic [63:0] scan_key_r;
  out_item_t   out_nxt;
  logic        strobe_r;

  logic [63:0] mem_key [TableDepth];
  logic [1:0]  mem_verd [TableDepth];
  logic [63:0] rd_key_r;
  logic [1:0]  rd_verd_r;
  logic        rd_valid_r;
  logic [IdxW-1:0] rd_idx_r;

  logic        is_param;
  logic        esc_first_c, fold_ch_c, line_end_c;
  logic [7:0]  fold_byte;
  logic        mem_we;
  logic [IdxW-1:0] mem_wa;
  logic [1:0]  mem_wv;

  // The FNV prime is 2^40 + 0x1b3, so the product is a short sum of shifts.
  function automatic logic [63:0] mul_prime(logic [63:0] x);
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  always_comb begin
    is_param = (item_r.ch >= 16'h0030 && item_r.ch <= 16'h0039) ||
               item_r.ch == ChSemi || item_r.ch == ChQuest;
    esc_first_c = 1'b0;
    fold_ch_c = 1'b0;
    mode_nxt = mode_r;
    case (mode_r)
      ModeEsc: begin
        if (item_r.ch == ChLbracket) begin
          mode_nxt = ModeCsi;
        end else begin
          esc_first_c = 1'b1;
          fold_ch_c = !(item_r.ch == ChEsc && !item_r.end_of_line);
          mode_nxt = fold_ch_c ? ModeNormal : ModeEsc;
        end
      end
      ModeCsi: begin
        if (!is_param) mode_nxt = ModeNormal;
      end
      default: begin
        fold_ch_c = !(item_r.ch == ChEsc && !item_r.end_of_line);
        mode_nxt = fold_ch_c ? ModeNormal : ModeEsc;
      end
    endcase
    line_end_c = item_r.end_of_line;
  end

  assign stat_o.fold_ch = fold_ch_c;
  assign stat_o.esc_first = esc_first_c;
  assign stat_o.line_end = line_end_c;
  assign stat_o.scan_done = rd_valid_r ? 1'b0 : (scan_idx_r >= entry_count_r);
  assign stat_o.cmd = item_r.cmd;

  // Byte order: a pending ESC low and high first, then the character low and high.
  always_comb begin
    if (esc_first_c && !byte_sel_r[1]) begin
      fold_byte = byte_sel_r[0] ? ChEsc[15:8] : ChEsc[7:0];
    end else begin
      fold_byte = byte_sel_r[0] ? item_r.ch[15:8] : item_r.ch[7:0];
    end
  end

  always_comb begin
    hash_nxt = hash_r;
    byte_sel_nxt = byte_sel_r;
    if (cmd_i.latch) begin
      byte_sel_nxt = 2'd0;
    end else if (cmd_i.fold) begin
      hash_nxt = mul_prime(hash_r ^ {56'd0, fold_byte});
      byte_sel_nxt = byte_sel_r + 2'd1;
    end
    if (cmd_i.fold_done && item_r.cmd == CmdChar && item_r.end_of_line) hash_nxt = FnvBasis;
  end

  // Commit of record / clear / line-end.
  always_comb begin
    prev_key_nxt = prev_key_r;
    key_ready_nxt = key_ready_r;
    entry_count_nxt = entry_count_r;
    dang_nxt = dang_r;
    trust_nxt = trust_r;
    mem_we = 1'b0;
    mem_wa = hit_idx_r;
    mem_wv = item_r.verdict_in;
    out_nxt.line_key = scan_key_r;
    out_nxt.found = hit_r;
    out_nxt.verdict_out = hit_r ? hit_verd_r : VerdNone;
    out_nxt.status = StOk;
    if (cmd_i.fold_done && item_r.end_of_line) begin
      prev_key_nxt = hash_r;
      key_ready_nxt = 1'b1;
    end
    if (cmd_i.commit) begin
      case (item_r.cmd)
        CmdRecord: begin
          if (!key_ready_r) begin
            out_nxt.status = StNoKey;
          end else if (item_r.verdict_in != VerdDanger && item_r.verdict_in != VerdTrust) begin
            out_nxt.status = StBadVerdict;
          end else if (hit_r) begin
            mem_we = 1'b1;
            if (hit_verd_r == VerdDanger) dang_nxt = dang_nxt - 1'b1;
            else trust_nxt = trust_nxt - 1'b1;
            if (item_r.verdict_in == VerdDanger) dang_nxt = dang_nxt + 1'b1;
            else trust_nxt = trust_nxt + 1'b1;
            out_nxt.found = 1'b1;
            out_nxt.verdict_out = item_r.verdict_in;
          end else if (entry_count_r >= CntW'(TableDepth)) begin
            out_nxt.status = StFull;
          end else begin
            mem_we = 1'b1;
            mem_wa = entry_count_r[IdxW-1:0];
            entry_count_nxt = entry_count_r + 1'b1;
            if (item_r.verdict_in == VerdDanger) dang_nxt = dang_r + 1'b1;
            else trust_nxt = trust_r + 1'b1;
            out_nxt.found = 1'b1;
            out_nxt.verdict_out = item_r.verdict_in;
          end
        end
        CmdClear: begin
          entry_count_nxt = '0;
          dang_nxt = '0;
          trust_nxt = '0;
          out_nxt.found = 1'b0;
          out_nxt.verdict_out = VerdNone;
        end
        default: begin
        end
      endcase
    end
    out_nxt.dangerous_total = 9'(dang_nxt);
    out_nxt.trusted_total = 9'(trust_nxt);
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch) item_r <= in_item;
    byte_sel_r <= byte_sel_nxt;
    if (cmd_i.scan_init) begin
      scan_key_r <= (item_r.cmd == CmdChar) ? hash_r : prev_key_r;
    end
    if (mem_we) begin
      mem_key[mem_wa] <= prev_key_r;
      mem_verd[mem_wa] <= mem_wv;
    end
    rd_key_r <= mem_key[scan_idx_r[IdxW-1:0]];
    rd_verd_r <= mem_verd[scan_idx_r[IdxW-1:0]];
    rd_idx_r <= scan_idx_r[IdxW-1:0];
    if (cmd_i.commit) out_item <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeNormal;
      hash_r <= FnvBasis;
      prev_key_r <= '0;
      key_ready_r <= 1'b0;
      entry_count_r <= '0;
      dang_r <= '0;
      trust_r <= '0;
      strobe_r <= 1'b0;
      scan_idx_r <= '0;
      rd_valid_r <= 1'b0;
      hit_r <= 1'b0;
      hit_idx_r <= '0;
      hit_verd_r <= VerdNone;
    end else begin
      if (cmd_i.fold_done) mode_r <= item_r.end_of_line ? ModeNormal : mode_nxt;
      hash_r <= hash_nxt;
      prev_key_r <= prev_key_nxt;
      key_ready_r <= key_ready_nxt;
      entry_count_r <= entry_count_nxt;
      dang_r <= dang_nxt;
      trust_r <= trust_nxt;
      strobe_r <= cmd_i.commit;
      if (cmd_i.scan_init) begin
        scan_idx_r <= '0;
        rd_valid_r <= 1'b0;
        hit_r <= 1'b0;
      end else if (cmd_i.scan_step) begin
        // One read issued per cycle; the registered word is compared next cycle.
        rd_valid_r <= scan_idx_r < entry_count_r;
        if (scan_idx_r < entry_count_r) scan_idx_r <= scan_idx_r + 1'b1;
        if (rd_valid_r && !hit_r && rd_key_r == scan_key_r) begin
          hit_r <= 1'b1;
          hit_idx_r <= rd_idx_r;
          hit_verd_r <= rd_verd_r;
        end
      end
    end
  end

  assign out_strobe = strobe_r;

endmodule

// ===== rtl/core/aslhvt_ctrl.sv =====
module aslhvt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  aslhvt_pkg::dp_stat_t stat_i,
  output aslhvt_pkg::dp_cmd_t  cmd_o
);
  import aslhvt_pkg::*;

  typedef enum logic [5:0] {
    SIdle   = 6'b000001,
    SDecode = 6'b000010,
    SFold   = 6'b000100,
    SScan   = 6'b001000,
    SCommit = 6'b010000,
    SDone   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] fold_cnt_r, fold_cnt_nxt;
  logic [2:0] fold_total;

  // Two bytes for a pending ESC and two for the character when each is hashed.
  assign fold_total = {stat_i.esc_first & stat_i.fold_ch,
                       stat_i.esc_first ^ stat_i.fold_ch, 1'b0};

  always_comb begin
    state_nxt = state_r;
    fold_cnt_nxt = fold_cnt_r;
    cmd_o = '0;
    case (state_r)
      SIdle: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_nxt = SDecode;
        end
      end
      SDecode: begin
        case (stat_i.cmd)
          CmdChar: begin
            fold_cnt_nxt = 3'd0;
            state_nxt = SFold;
          end
          CmdRecord, CmdClear: begin
            cmd_o.scan_init = 1'b1;
            state_nxt = SScan;
          end
          default: state_nxt = SIdle;
        endcase
      end
      SFold: begin
        if (fold_cnt_r == fold_total) begin
          cmd_o.fold_done = 1'b1;
          if (stat_i.line_end) begin
            cmd_o.scan_init = 1'b1;
            state_nxt = SScan;
          end else begin
            state_nxt = SIdle;
          end
        end else begin
          cmd_o.fold = 1'b1;
          fold_cnt_nxt = fold_cnt_r + 3'd1;
        end
      end
      SScan: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) state_nxt = SCommit;
      end
      SCommit: begin
        cmd_o.commit = 1'b1;
        state_nxt = SDone;
      end
      SDone: state_nxt = SIdle;
      default: state_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SIdle;
      fold_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      fold_cnt_r <= fold_cnt_nxt;
    end
  end

  assign busy = (state_r != SIdle);

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register lost one-hot encoding");
  a_commit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.commit |-> $past(state_r == SScan))
    else $error("commit without a finished scan");
  a_fold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fold_cnt_r <= 3'd4)
    else $error("more than four byte folds for one character");

endmodule

// ===== rtl/core/ansi_stripped_line_hash_verdict_table_top.sv =====
// A character without end mark keeps busy high through decode, zero, two or four byte folds
// and a close; the block takes one item at a time.
// A line end, record or clear adds a table scan over the valid entries, then a commit state
// and the SDone state in which out_valid strobes the result.
// The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset (rst_n low, synchronous) empties the table, clears counts, key and strip mode.
module ansi_stripped_line_hash_verdict_table_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  aslhvt_pkg::in_item_t  in_item,
  output logic                  out_valid,
  output aslhvt_pkg::out_item_t out_item
);
  import aslhvt_pkg::*;

  // The controller sequences each transfer; the datapath holds the hash,
  // the strip mode, the verdict memory and the counters.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  aslhvt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  aslhvt_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .out_item   (out_item),
    .out_strobe (out_valid)
  );

endmodule

// ===== tb/ansi_stripped_line_hash_verdict_table_top_test.sv =====
`timescale 1ns / 100ps

module ansi_stripped_line_hash_verdict_table_top_test;
  import aslhvt_pkg::*;

  localparam int IdleLimit = 4000;
  localparam int DrainCycles = 600;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;

  ansi_stripped_line_hash_verdict_table_top i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  // Predicted state of the block, kept in step with every accepted transfer.
  typedef enum logic [1:0] {StripNormal, StripEsc, StripCsi} strip_e;

  strip_e pm_mode;
  logic [63:0] pm_hash;
  logic [63:0] pm_last_key;
  logic pm_key_ready;
  logic [63:0] pm_keys[TableDepth];
  logic [1:0] pm_verds[TableDepth];
  int pm_entries;
  int pm_danger;
  int pm_trust;

  in_item_t pending_items[$];
  out_item_t expected_lookups[$];

  int errors;
  int idle_cycles;
  int accepted_items;
  int checked_lookups;
  int full_hits;
  bit stimulus_done;
  bit quiet_stretch;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] fnv_fold(logic [63:0] h, logic [15:0] c);
    logic [63:0] r;
    r = (h ^ {56'd0, c[7:0]}) * FnvPrime;
    r = (r ^ {56'd0, c[15:8]}) * FnvPrime;
    return r;
  endfunction

  function automatic bit is_csi_param(logic [15:0] c);
    return (c >= 16'h0030 && c <= 16'h0039) || c == ChSemi || c == ChQuest;
  endfunction

  function automatic int find_entry(logic [63:0] key);
    for (int i = 0; i < pm_entries; i++) begin
      if (pm_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic out_item_t lookup_result(logic [63:0] key, logic [1:0] st);
    out_item_t r;
    int idx;
    idx = find_entry(key);
    r.line_key = key;
    r.found = (idx >= 0);
    r.verdict_out = (idx >= 0) ? pm_verds[idx] : VerdNone;
    r.dangerous_total = pm_danger[8:0];
    r.trusted_total = pm_trust[8:0];
    r.status = st;
    return r;
  endfunction

  // Normal-mode handling: an ESC that does not end the line is held back.
  task automatic plain_char(logic [15:0] c, logic last);
    if (c == ChEsc && !last) pm_mode = StripEsc;
    else pm_hash = fnv_fold(pm_hash, c);
  endtask

  // Advances the predicted state by one transfer and queues any lookup it yields.
  task automatic predict_lookup(in_item_t it);
    logic [1:0] st;
    int idx;
    case (it.cmd)
      CmdChar: begin
        if (pm_mode == StripEsc) begin
          if (it.ch == ChLbracket) begin
            pm_mode = StripCsi;
          end else begin
            pm_hash = fnv_fold(pm_hash, ChEsc);
            pm_mode = StripNormal;
            plain_char(it.ch, it.end_of_line);
          end
        end else if (pm_mode == StripCsi) begin
          if (!is_csi_param(it.ch)) pm_mode = StripNormal;
        end else begin
          plain_char(it.ch, it.end_of_line);
        end
        if (it.end_of_line) begin
          pm_last_key = pm_hash;
          pm_key_ready = 1'b1;
          pm_hash = FnvBasis;
          pm_mode = StripNormal;
          expected_lookups.insert(expected_lookups.size(), lookup_result(pm_last_key, StOk));
        end
      end
      CmdRecord: begin
        st = StOk;
        if (!pm_key_ready) begin
          st = StNoKey;
        end else if (it.verdict_in != VerdDanger && it.verdict_in != VerdTrust) begin
          st = StBadVerdict;
        end else begin
          idx = find_entry(pm_last_key);
          if (idx >= 0) begin
            if (pm_verds[idx] == VerdDanger) pm_danger--;
            else pm_trust--;
            pm_verds[idx] = it.verdict_in;
            if (it.verdict_in == VerdDanger) pm_danger++;
            else pm_trust++;
          end else if (pm_entries >= TableDepth) begin
            st = StFull;
            full_hits++;
          end else begin
            pm_keys[pm_entries] = pm_last_key;
            pm_verds[pm_entries] = it.verdict_in;
            pm_entries++;
            if (it.verdict_in == VerdDanger) pm_danger++;
            else pm_trust++;
          end
        end
        expected_lookups.insert(expected_lookups.size(), lookup_result(pm_last_key, st));
      end
      CmdClear: begin
        pm_entries = 0;
        pm_danger = 0;
        pm_trust = 0;
        expected_lookups.insert(expected_lookups.size(), lookup_result(pm_last_key, StOk));
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic push_item(logic [1:0] cmd, logic [15:0] ch, logic eol, logic [1:0] v);
    in_item_t it;
    it.cmd = cmd;
    it.ch = ch;
    it.end_of_line = eol;
    it.verdict_in = v;
    pending_items.insert(pending_items.size(), it);
  endtask

  // A random character, biased toward the ones that steer the CSI stripper.
  function automatic logic [15:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1: return ChEsc;
      2: return ChLbracket;
      3: return ($urandom_range(0, 1) != 0) ? ChSemi : ChQuest;
      4: return 16'h0030 + 16'($urandom_range(0, 9));
      5: return 16'($urandom);
      default: return 16'h0020 + 16'($urandom_range(0, 94));
    endcase
  endfunction

  // Short random lines, with an optional CSI sequence in the middle and now and then a final ESC.
  task automatic push_line(int seed_len, bit with_csi);
    int n;
    n = seed_len;
    for (int i = 0; i < n; i++) begin
      if (with_csi && i == n / 2) begin
        push_item(CmdChar, ChEsc, 1'b0, 2'($urandom));
        push_item(CmdChar, ChLbracket, 1'b0, 2'($urandom));
        push_item(CmdChar, 16'h0031, 1'b0, 2'($urandom));
        push_item(CmdChar, ChSemi, 1'b0, 2'($urandom));
        push_item(CmdChar, 16'h006d, 1'b0, 2'($urandom));
      end
      push_item(CmdChar, (i == n - 1 && $urandom_range(0, 15) == 0) ? ChEsc : pick_char(),
                i == n - 1, 2'($urandom));
    end
  endtask

  // Driver: presents the oldest pending item and drops it once it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_lookup(in_item);
        accepted_items++;
        void'(pending_items.pop_front());
      end
      if (start && busy) begin
        // The offered item stays on the ports until the block takes it.
      end else if (pending_items.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 9)) begin
        in_item <= pending_items[0];
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe is a result transfer matched against the oldest lookup.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("unexpected result", out_item.line_key, 64'd0);
      end else begin
        want = expected_lookups.pop_front();
        checked_lookups++;
        if (out_item.line_key !== want.line_key)
          report_mismatch("line_key", out_item.line_key, want.line_key);
        if (out_item.found !== want.found)
          report_mismatch("found", 64'(out_item.found), 64'(want.found));
        if (out_item.verdict_out !== want.verdict_out)
          report_mismatch("verdict_out", 64'(out_item.verdict_out), 64'(want.verdict_out));
        if (out_item.dangerous_total !== want.dangerous_total)
          report_mismatch("dangerous_total", 64'(out_item.dangerous_total),
                          64'(want.dangerous_total));
        if (out_item.trusted_total !== want.trusted_total)
          report_mismatch("trusted_total", 64'(out_item.trusted_total),
                          64'(want.trusted_total));
        if (out_item.status !== want.status)
          report_mismatch("status", 64'(out_item.status), 64'(want.status));
      end
    end
  end

  // Watchdog: counts cycles in which neither an item nor a result is accepted.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit && !stimulus_done) begin
      $display("Watchdog expired with %0d items pending", pending_items.size());
      $display("** ansi_stripped_line_hash_verdict_table_top: FAILED **");
      $finish;
    end
  end

  initial begin
    int mode;
    int waited;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    errors = 0;
    accepted_items = 0;
    checked_lookups = 0;
    full_hits = 0;
    stimulus_done = 1'b0;
    quiet_stretch = 1'b0;
    pm_mode = StripNormal;
    pm_hash = FnvBasis;
    pm_last_key = '0;
    pm_key_ready = 1'b0;
    pm_entries = 0;
    pm_danger = 0;
    pm_trust = 0;

    // Directed part: record before any line, the ESC corner cases, a CSI that
    // runs off the end of a line, every command and the extremes of each field.
    push_item(CmdRecord, 16'h0000, 1'b0, VerdDanger);
    push_item(CmdChar, 16'hffff, 1'b0, 2'd3);
    push_item(CmdChar, 16'h0000, 1'b1, 2'd0);
    push_item(CmdRecord, 16'hffff, 1'b1, 2'd0);
    push_item(CmdRecord, 16'h0000, 1'b0, 2'd3);
    push_item(CmdRecord, 16'h0000, 1'b0, VerdDanger);
    push_item(CmdRecord, 16'h0000, 1'b0, VerdTrust);
    push_item(CmdChar, ChEsc, 1'b1, 2'd0);
    push_item(CmdRecord, 16'h0000, 1'b0, VerdTrust);
    push_item(CmdChar, ChEsc, 1'b0, 2'd0);
    push_item(CmdChar, 16'h0041, 1'b1, 2'd0);
    push_item(CmdChar, ChEsc, 1'b0, 2'd0);
    push_item(CmdChar, ChEsc, 1'b1, 2'd0);
    push_item(CmdChar, ChEsc, 1'b0, 2'd0);
    push_item(CmdChar, ChLbracket, 1'b0, 2'd0);
    push_item(CmdChar, ChQuest, 1'b1, 2'd0);
    push_item(CmdChar, ChEsc, 1'b0, 2'd0);
    push_item(CmdChar, ChLbracket, 1'b1, 2'd0);
    push_item(2'd3, 16'h1234, 1'b1, VerdDanger);
    push_item(CmdClear, 16'h0000, 1'b0, 2'd0);
    push_item(CmdRecord, 16'h0000, 1'b0, VerdDanger);

    // Fill the table past its depth so the full status shows, then clear it.
    for (int k = 0; k < TableDepth + 3; k++) begin
      push_item(CmdChar, 16'(k), 1'b0, 2'd0);
      push_item(CmdChar, 16'(k >> 4), 1'b1, 2'd0);
      push_item(CmdRecord, 16'h0000, 1'b0, (k % 3 == 0) ? VerdTrust : VerdDanger);
    end
    push_item(CmdChar, 16'd5, 1'b0, 2'd0);
    push_item(CmdChar, 16'd0, 1'b1, 2'd0);
    push_item(CmdRecord, 16'h0000, 1'b0, VerdTrust);
    push_item(CmdClear, 16'hffff, 1'b1, 2'd3);

    // Random part: mostly whole lines followed by records, some noise between.
    while (pending_items.size() < 1500) begin
      mode = $urandom_range(0, 19);
      if (mode < 12) begin
        push_line($urandom_range(1, 5), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0)
          push_item(CmdRecord, 16'($urandom), 1'($urandom),
                    ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2)));
      end else if (mode < 17) begin
        push_item(CmdChar, pick_char(), 1'($urandom), 2'($urandom));
      end else if (mode < 18) begin
        push_item(CmdClear, 16'($urandom), 1'($urandom), 2'($urandom));
      end else begin
        push_item(2'($urandom_range(1, 3)), 16'($urandom), 1'($urandom), 2'($urandom));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // A stretch without any idling on the input side.
    while (pending_items.size() > 600) begin
      quiet_stretch = (pending_items.size() < 1000);
      @(posedge clk);
    end
    quiet_stretch = 1'b0;
    while (pending_items.size() > 0) @(posedge clk);
    stimulus_done = 1'b1;

    waited = 0;
    while (expected_lookups.size() > 0 && waited < 20 * IdleLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Accepted %0d items and checked %0d lookups, %0d of them with the table full.",
             accepted_items, checked_lookups, full_hits);
    if (errors == 0 && expected_lookups.size() == 0) begin
      $display("** ansi_stripped_line_hash_verdict_table_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d lookups never seen", errors, expected_lookups.size());
      $display("** ansi_stripped_line_hash_verdict_table_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/aslhvt_pkg.sv
rtl/core/aslhvt_datapath.sv
rtl/core/aslhvt_ctrl.sv
rtl/core/ansi_stripped_line_hash_verdict_table_top.sv
tb/ansi_stripped_line_hash_verdict_table_top_test.sv
